[design/twsi_pkg.sv]
`default_nettype none

package twsi_pkg;

    localparam logic [3:0] TAG_NUMBER = 4'd8;
    localparam logic [3:0] TAG_NAME   = 4'd1;

    localparam logic [31:0] NAME_MASK  = 32'hffff_fff0;
    localparam logic [31:0] NAME_COMMA = 32'hfc00_0000;
    localparam logic [31:0] NAME_FORTH = 32'hb189_6400;
    localparam logic [31:0] NAME_MACRO = 32'h8ac8_4c00;
    localparam logic [31:0] NAME_DOT   = 32'hea00_0000;
    localparam logic [31:0] NAME_ADD   = 32'hf600_0000;
    localparam logic [31:0] NAME_DIV   = 32'hee00_0000;
    localparam logic [31:0] NAME_SUB   = 32'he600_0000;
    localparam logic [31:0] NAME_MUL   = 32'hfa00_0000;
    localparam logic [31:0] NAME_DUP   = 32'hc19b_1000;
    localparam logic [31:0] NAME_ZAP   = 32'hecb8_8000;
    localparam logic [31:0] NAME_NIP   = 32'h67c4_0000;
    localparam logic [31:0] NAME_SWAP  = 32'h85d7_1000;
    localparam logic [31:0] NAME_OVER  = 32'h3c28_2000;
    localparam logic [31:0] NAME_LEAP  = 32'ha22e_2000;
    localparam logic [31:0] NAME_EQL   = 32'h4cf4_fe00;
    localparam logic [31:0] NAME_ZERO  = 32'hec82_7fc0;

    localparam logic [2:0] STATUS_DONE    = 3'd0;
    localparam logic [2:0] STATUS_IGNORED = 3'd1;
    localparam logic [2:0] STATUS_UNDER   = 3'd2;
    localparam logic [2:0] STATUS_OVER    = 3'd3;
    localparam logic [2:0] STATUS_DIVZERO = 3'd4;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_NOP,
        OP_PUSH,
        OP_DOT,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_DUP,
        OP_ZAP,
        OP_NIP,
        OP_SWAP,
        OP_OVER,
        OP_LEAP,
        OP_EQL,
        OP_ZERO
    } op_t;

    // One classified request: the operation and, for a number, the value to push.
    typedef struct packed {
        op_t         op;
        logic [31:0] value;
    } item_t;

endpackage

`default_nettype wire

[design/twsi_front.sv]
`default_nettype none

module twsi_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            src_valid,
    output logic                 src_stall,
    input  wire logic [31:0]     source_word,
    output logic                 item_valid,
    output twsi_pkg::item_t      item,
    input  wire logic            item_taken
);

    logic            item_valid_reg;
    twsi_pkg::item_t item_reg;
    twsi_pkg::item_t item_next;
    twsi_pkg::op_t   name_op;

    always_comb
    begin
        unique case (source_word & twsi_pkg::NAME_MASK)
            twsi_pkg::NAME_COMMA: name_op = twsi_pkg::OP_NOP;
            twsi_pkg::NAME_FORTH: name_op = twsi_pkg::OP_NOP;
            twsi_pkg::NAME_MACRO: name_op = twsi_pkg::OP_NOP;
            twsi_pkg::NAME_DOT:   name_op = twsi_pkg::OP_DOT;
            twsi_pkg::NAME_ADD:   name_op = twsi_pkg::OP_ADD;
            twsi_pkg::NAME_DIV:   name_op = twsi_pkg::OP_DIV;
            twsi_pkg::NAME_SUB:   name_op = twsi_pkg::OP_SUB;
            twsi_pkg::NAME_MUL:   name_op = twsi_pkg::OP_MUL;
            twsi_pkg::NAME_DUP:   name_op = twsi_pkg::OP_DUP;
            twsi_pkg::NAME_ZAP:   name_op = twsi_pkg::OP_ZAP;
            twsi_pkg::NAME_NIP:   name_op = twsi_pkg::OP_NIP;
            twsi_pkg::NAME_SWAP:  name_op = twsi_pkg::OP_SWAP;
            twsi_pkg::NAME_OVER:  name_op = twsi_pkg::OP_OVER;
            twsi_pkg::NAME_LEAP:  name_op = twsi_pkg::OP_LEAP;
            twsi_pkg::NAME_EQL:   name_op = twsi_pkg::OP_EQL;
            twsi_pkg::NAME_ZERO:  name_op = twsi_pkg::OP_ZERO;
            default:              name_op = twsi_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        // A number is the word shifted right by five with its sign kept.
        item_next.value = {{5{source_word[31]}}, source_word[31:5]};
        unique case (source_word[3:0])
            twsi_pkg::TAG_NUMBER: item_next.op = twsi_pkg::OP_PUSH;
            twsi_pkg::TAG_NAME:   item_next.op = name_op;
            default:              item_next.op = twsi_pkg::OP_NONE;
        endcase
    end

    assign src_stall  = item_valid_reg && !item_taken;
    assign item_valid = item_valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (src_valid && !src_stall)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (item_taken)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

[design/twsi_queue.sv]
`default_nettype none

module twsi_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire twsi_pkg::item_t push_item,
    output logic                 full,
    input  wire logic            pop,
    output logic                 not_empty,
    output twsi_pkg::item_t      head
);

    twsi_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[design/twsi_exec.sv]
`default_nettype none

module twsi_exec #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire twsi_pkg::item_t    q_item,
    output logic                    q_pop,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [2:0]              status,
    output logic                    shown_valid,
    output logic signed [31:0]      shown_value,
    output logic [6:0]              depth,
    output logic signed [31:0]      top_value
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [4:0] DIV_LAST = 5'd31;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ_B,
        S_READ_C,
        S_EXEC,
        S_DIV,
        S_SIGN,
        S_WRITE,
        S_SWAP2,
        S_FINISH
    } state_t;

    function automatic logic [1:0] op_need(twsi_pkg::op_t op);
        logic [1:0] n;
        case (op) inside
            twsi_pkg::OP_DOT, twsi_pkg::OP_DUP, twsi_pkg::OP_ZAP,
            twsi_pkg::OP_ZERO:                                      n = 2'd1;
            twsi_pkg::OP_ADD, twsi_pkg::OP_SUB, twsi_pkg::OP_MUL,
            twsi_pkg::OP_DIV, twsi_pkg::OP_NIP, twsi_pkg::OP_SWAP,
            twsi_pkg::OP_OVER, twsi_pkg::OP_EQL:                    n = 2'd2;
            twsi_pkg::OP_LEAP:                                      n = 2'd3;
            default:                                                n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic op_grows(twsi_pkg::op_t op);
        logic g;
        case (op) inside
            twsi_pkg::OP_PUSH, twsi_pkg::OP_DUP, twsi_pkg::OP_OVER,
            twsi_pkg::OP_LEAP: g = 1'b1;
            default:           g = 1'b0;
        endcase
        return g;
    endfunction

    logic [31:0]   stack_mem [STACK_DEPTH];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;

    state_t        state_reg;
    twsi_pkg::op_t op_reg;
    logic [DW-1:0] depth_reg;
    logic [31:0]   top_reg;
    logic [31:0]   b_reg;
    logic [31:0]   c_reg;
    logic [31:0]   alu_reg;
    logic [2:0]    stat_reg;
    logic          shown_valid_reg;
    logic [31:0]   shown_reg;

    logic [31:0]   quot_reg;
    logic [31:0]   rem_reg;
    logic [31:0]   dvs_reg;
    logic          neg_reg;
    logic [4:0]    cnt_reg;

    logic          res_valid_reg;
    logic [2:0]    res_status_reg;
    logic          res_shown_valid_reg;
    logic [31:0]   res_shown_reg;
    logic [6:0]    res_depth_reg;
    logic [31:0]   res_top_reg;

    logic [DW-1:0] dm1;
    logic [DW-1:0] dm2;
    logic [DW-1:0] dm3;
    logic [DW+6:0] depth_ext;
    logic          out_free;
    logic [1:0]    need;
    logic [31:0]   product;
    logic [32:0]   rem_shift;
    logic [33:0]   trial;

    assign dm1       = depth_reg - DW'(1);
    assign dm2       = depth_reg - DW'(2);
    assign dm3       = depth_reg - DW'(3);
    assign depth_ext = (DW + 7)'(depth_reg);
    assign out_free  = !res_valid_reg || !res_stall;
    assign need      = op_need(q_item.op);
    assign q_pop     = (state_reg == S_IDLE) && q_valid && out_free;
    assign product   = b_reg * top_reg;
    assign rem_shift = {rem_reg, quot_reg[31]};
    assign trial     = {1'b0, rem_shift} - {2'b00, dvs_reg};

    assign res_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign shown_valid = res_shown_valid_reg;
    assign shown_value = $signed(res_shown_reg);
    assign depth       = res_depth_reg;
    assign top_value   = $signed(res_top_reg);

    // The two operands below the top are fetched one per cycle.
    always_comb
    begin
        if (state_reg == S_READ_B)
        begin
            rd_addr = dm3[AW-1:0];
        end
        else
        begin
            rd_addr = dm2[AW-1:0];
        end
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = dm2[AW-1:0];
        mem_wd = alu_reg;
        if (state_reg == S_WRITE)
        begin
            case (op_reg) inside
                twsi_pkg::OP_PUSH, twsi_pkg::OP_DUP, twsi_pkg::OP_OVER,
                twsi_pkg::OP_LEAP:
                begin
                    mem_we = 1'b1;
                    mem_wa = depth_reg[AW-1:0];
                end
                twsi_pkg::OP_ADD, twsi_pkg::OP_SUB, twsi_pkg::OP_MUL,
                twsi_pkg::OP_DIV, twsi_pkg::OP_NIP, twsi_pkg::OP_EQL:
                begin
                    mem_we = 1'b1;
                end
                twsi_pkg::OP_ZERO:
                begin
                    mem_we = 1'b1;
                    mem_wa = dm1[AW-1:0];
                end
                twsi_pkg::OP_SWAP:
                begin
                    mem_we = 1'b1;
                    mem_wd = top_reg;
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_SWAP2)
        begin
            mem_we = 1'b1;
            mem_wa = dm1[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            top_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && out_free)
                    begin
                        op_reg          <= q_item.op;
                        alu_reg         <= q_item.value;
                        shown_valid_reg <= 1'b0;
                        shown_reg       <= '0;
                        stat_reg        <= twsi_pkg::STATUS_DONE;
                        if (q_item.op == twsi_pkg::OP_NONE)
                        begin
                            stat_reg  <= twsi_pkg::STATUS_IGNORED;
                            state_reg <= S_FINISH;
                        end
                        else if (depth_reg < DW'(need))
                        begin
                            stat_reg  <= twsi_pkg::STATUS_UNDER;
                            state_reg <= S_FINISH;
                        end
                        else if (op_grows(q_item.op) && depth_reg == DW'(STACK_DEPTH))
                        begin
                            stat_reg  <= twsi_pkg::STATUS_OVER;
                            state_reg <= S_FINISH;
                        end
                        else if (q_item.op == twsi_pkg::OP_NOP)
                        begin
                            state_reg <= S_FINISH;
                        end
                        else if (q_item.op == twsi_pkg::OP_PUSH)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            state_reg <= S_READ_B;
                        end
                    end
                end

                S_READ_B:
                begin
                    b_reg     <= (depth_reg >= DW'(2)) ? rd_data_reg : '0;
                    state_reg <= S_READ_C;
                end

                S_READ_C:
                begin
                    c_reg     <= (depth_reg >= DW'(3)) ? rd_data_reg : '0;
                    state_reg <= S_EXEC;
                end

                S_EXEC:
                begin
                    state_reg <= S_WRITE;
                    case (op_reg)
                        twsi_pkg::OP_ADD:  alu_reg <= b_reg + top_reg;
                        twsi_pkg::OP_SUB:  alu_reg <= b_reg - top_reg;
                        twsi_pkg::OP_MUL:  alu_reg <= product;
                        twsi_pkg::OP_NIP:  alu_reg <= top_reg;
                        twsi_pkg::OP_EQL:  alu_reg <= {31'd0, b_reg == top_reg};
                        twsi_pkg::OP_ZERO: alu_reg <= {31'd0, top_reg == 32'd0};
                        twsi_pkg::OP_DUP:  alu_reg <= top_reg;
                        twsi_pkg::OP_OVER: alu_reg <= b_reg;
                        twsi_pkg::OP_LEAP: alu_reg <= c_reg;
                        twsi_pkg::OP_SWAP: alu_reg <= b_reg;
                        twsi_pkg::OP_ZAP:  alu_reg <= b_reg;
                        twsi_pkg::OP_DOT:
                        begin
                            alu_reg         <= b_reg;
                            shown_valid_reg <= 1'b1;
                            shown_reg       <= top_reg;
                        end
                        twsi_pkg::OP_DIV:
                        begin
                            if (top_reg == 32'd0)
                            begin
                                stat_reg  <= twsi_pkg::STATUS_DIVZERO;
                                state_reg <= S_FINISH;
                            end
                            else
                            begin
                                // Divide magnitudes, then fix the sign.
                                quot_reg  <= b_reg[31] ? (32'd0 - b_reg) : b_reg;
                                dvs_reg   <= top_reg[31] ? (32'd0 - top_reg) : top_reg;
                                neg_reg   <= b_reg[31] ^ top_reg[31];
                                rem_reg   <= '0;
                                cnt_reg   <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                        default:           alu_reg <= top_reg;
                    endcase
                end

                S_DIV:
                begin
                    if (!trial[33])
                    begin
                        rem_reg  <= trial[31:0];
                        quot_reg <= {quot_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_shift[31:0];
                        quot_reg <= {quot_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        state_reg <= S_SIGN;
                    end
                end

                S_SIGN:
                begin
                    alu_reg   <= neg_reg ? (32'd0 - quot_reg) : quot_reg;
                    state_reg <= S_WRITE;
                end

                S_WRITE:
                begin
                    case (op_reg) inside
                        twsi_pkg::OP_PUSH, twsi_pkg::OP_DUP, twsi_pkg::OP_OVER,
                        twsi_pkg::OP_LEAP:
                        begin
                            depth_reg <= depth_reg + DW'(1);
                        end
                        twsi_pkg::OP_ADD, twsi_pkg::OP_SUB, twsi_pkg::OP_MUL,
                        twsi_pkg::OP_DIV, twsi_pkg::OP_NIP, twsi_pkg::OP_EQL,
                        twsi_pkg::OP_DOT, twsi_pkg::OP_ZAP:
                        begin
                            depth_reg <= dm1;
                        end
                        default:
                        begin
                            depth_reg <= depth_reg;
                        end
                    endcase
                    // Swap keeps the old top until its second write is done.
                    if (op_reg == twsi_pkg::OP_SWAP)
                    begin
                        state_reg <= S_SWAP2;
                    end
                    else
                    begin
                        top_reg   <= alu_reg;
                        state_reg <= S_FINISH;
                    end
                end

                S_SWAP2:
                begin
                    top_reg   <= alu_reg;
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    res_valid_reg       <= 1'b1;
                    res_status_reg      <= stat_reg;
                    res_shown_valid_reg <= shown_valid_reg;
                    res_shown_reg       <= shown_reg;
                    res_depth_reg       <= depth_ext[6:0];
                    res_top_reg         <= top_reg;
                    state_reg           <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[design/tagged_word_stack_interpreter_core.sv]
// Tagged word stack interpreter.
// Requests arrive on the src channel (src_valid, src_stall, source_word); each
// request is one 32-bit word whose low four bits are the tag. A number word is
// pushed; a known name word runs a primitive; anything else is reported ignored.
// Every request yields exactly one result on the res channel (res_valid,
// res_stall) carrying status, shown_valid/shown_value, depth and top_value.
// A front stage decodes the word and hands it through a two-entry queue to an
// execution unit that owns the stack memory, so the source side keeps moving
// while the execution unit works or the result waits to be taken.
// An ignored word, an error or a no-op goes straight to the result; a number is
// first written to the stack; a primitive fetches its operands, executes and
// writes back (swap writes twice, a divide by zero stops after executing), and
// a divide runs a one-bit-per-cycle restoring divider before its write. The
// stack memory has a single read port, so operands are fetched one per cycle.
// The execution unit takes one request at a time.
// Results come out in request order; while res_stall is high the result holds
// and the execution unit waits, and the queue then fills and raises src_stall.
// Reset empties the stack and the queue and drops any pending result.
`default_nettype none

module tagged_word_stack_interpreter_core #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire logic [31:0]        source_word,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output logic [2:0]              status,
    output logic                    shown_valid,
    output logic signed [31:0]      shown_value,
    output logic [6:0]              depth,
    output logic signed [31:0]      top_value
);

    logic            item_valid;
    twsi_pkg::item_t item;
    logic            q_full;
    logic            q_push;
    logic            q_not_empty;
    logic            q_pop;
    twsi_pkg::item_t q_head;

    assign q_push = item_valid && !q_full;

    twsi_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .source_word (source_word),
        .item_valid  (item_valid),
        .item        (item),
        .item_taken  (!q_full)
    );

    twsi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    twsi_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_item      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .status      (status),
        .shown_valid (shown_valid),
        .shown_value (shown_value),
        .depth       (depth),
        .top_value   (top_value)
    );

endmodule

`default_nettype wire

[tb/tb_tagged_word_stack_interpreter_core.sv]
`timescale 1ns / 1ps

module tb_tagged_word_stack_interpreter_core;

    localparam int STACK_DEPTH = 64;
    localparam int RANDOM_REQUESTS = 474;

    typedef struct packed {
        logic [2:0]  status;
        logic        shown_valid;
        logic [31:0] shown_value;
        logic [6:0]  depth;
        logic [31:0] top_value;
    } outcome_t;

    typedef struct packed {
        logic [31:0] word;
        logic        typed;
        outcome_t    want;
    } script_row_t;

    localparam outcome_t NO_VALUE = '0;

    // Rows with typed outcomes can be read straight off the stack contents;
    // the rest are checked against the predictor.
    localparam script_row_t SCRIPT [26] = '{
        '{{twsi_pkg::NAME_DOT[31:4], twsi_pkg::TAG_NAME}, 1'b1,
          '{twsi_pkg::STATUS_UNDER, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{32'h0000_0000, 1'b1, '{twsi_pkg::STATUS_IGNORED, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{32'hffff_ffff, 1'b1, '{twsi_pkg::STATUS_IGNORED, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{{28'h123_4567, twsi_pkg::TAG_NAME}, 1'b1,
          '{twsi_pkg::STATUS_IGNORED, 1'b0, 32'd0, 7'd0, 32'd0}},
        '{{27'h3ff_ffff, 1'b1, twsi_pkg::TAG_NUMBER}, 1'b1,
          '{twsi_pkg::STATUS_DONE, 1'b0, 32'd0, 7'd1, 32'h03ff_ffff}},
        '{{27'h400_0000, 1'b0, twsi_pkg::TAG_NUMBER}, 1'b1,
          '{twsi_pkg::STATUS_DONE, 1'b0, 32'd0, 7'd2, 32'hfc00_0000}},
        '{{27'd32, 1'b0, twsi_pkg::TAG_NUMBER}, 1'b1,
          '{twsi_pkg::STATUS_DONE, 1'b0, 32'd0, 7'd3, 32'd32}},
        '{{twsi_pkg::NAME_MUL[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{27'h7ff_ffff, 1'b1, twsi_pkg::TAG_NUMBER}, 1'b1,
          '{twsi_pkg::STATUS_DONE, 1'b0, 32'd0, 7'd3, 32'hffff_ffff}},
        '{{twsi_pkg::NAME_DIV[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{27'd0, 1'b0, twsi_pkg::TAG_NUMBER}, 1'b1,
          '{twsi_pkg::STATUS_DONE, 1'b0, 32'd0, 7'd3, 32'd0}},
        '{{twsi_pkg::NAME_DIV[31:4], twsi_pkg::TAG_NAME}, 1'b1,
          '{twsi_pkg::STATUS_DIVZERO, 1'b0, 32'd0, 7'd3, 32'd0}},
        '{{twsi_pkg::NAME_ZAP[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_DUP[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_SWAP[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_OVER[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_LEAP[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_EQL[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_ZERO[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_NIP[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_SUB[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_ADD[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_COMMA[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_FORTH[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_MACRO[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE},
        '{{twsi_pkg::NAME_DOT[31:4], twsi_pkg::TAG_NAME}, 1'b0, NO_VALUE}
    };

    localparam logic [31:0] KNOWN_NAMES [16] = '{
        twsi_pkg::NAME_COMMA, twsi_pkg::NAME_FORTH, twsi_pkg::NAME_MACRO,
        twsi_pkg::NAME_DOT, twsi_pkg::NAME_ADD, twsi_pkg::NAME_DIV,
        twsi_pkg::NAME_SUB, twsi_pkg::NAME_MUL, twsi_pkg::NAME_DUP,
        twsi_pkg::NAME_ZAP, twsi_pkg::NAME_NIP, twsi_pkg::NAME_SWAP,
        twsi_pkg::NAME_OVER, twsi_pkg::NAME_LEAP, twsi_pkg::NAME_EQL,
        twsi_pkg::NAME_ZERO
    };

    logic               clk = 1'b0;
    logic               rst_n;
    logic               src_valid;
    logic               src_stall;
    logic [31:0]        source_word;
    logic               res_valid;
    logic               res_stall;
    logic [2:0]         status;
    logic               shown_valid;
    logic signed [31:0] shown_value;
    logic [6:0]         depth;
    logic signed [31:0] top_value;

    logic [31:0] word_stack [STACK_DEPTH];
    int          stack_fill;
    outcome_t    pending_results [$];
    int          mismatch_count;
    int          requests_taken;
    int          burst_left;

    tagged_word_stack_interpreter_core #(
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .src_valid(src_valid),
        .src_stall(src_stall),
        .source_word(source_word),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .status(status),
        .shown_valid(shown_valid),
        .shown_value(shown_value),
        .depth(depth),
        .top_value(top_value)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40)
        begin
            $display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // Executes one source word on the shadow stack and returns the result it yields.
    function automatic outcome_t interpret_word(logic [31:0] w);
        outcome_t      o;
        twsi_pkg::op_t op;
        int            need;
        int            give;
        int            d;
        logic [31:0]   a;
        logic [31:0]   b;
        logic [31:0]   c;
        o = '0;
        o.status = twsi_pkg::STATUS_IGNORED;
        op = twsi_pkg::OP_NONE;
        need = 0;
        give = 0;
        if (w[3:0] == twsi_pkg::TAG_NUMBER)
        begin
            op = twsi_pkg::OP_PUSH;
        end
        else if (w[3:0] == twsi_pkg::TAG_NAME)
        begin
            case (w & twsi_pkg::NAME_MASK)
                twsi_pkg::NAME_COMMA, twsi_pkg::NAME_FORTH,
                twsi_pkg::NAME_MACRO: op = twsi_pkg::OP_NOP;
                twsi_pkg::NAME_DOT:  op = twsi_pkg::OP_DOT;
                twsi_pkg::NAME_ADD:  op = twsi_pkg::OP_ADD;
                twsi_pkg::NAME_SUB:  op = twsi_pkg::OP_SUB;
                twsi_pkg::NAME_MUL:  op = twsi_pkg::OP_MUL;
                twsi_pkg::NAME_DIV:  op = twsi_pkg::OP_DIV;
                twsi_pkg::NAME_DUP:  op = twsi_pkg::OP_DUP;
                twsi_pkg::NAME_ZAP:  op = twsi_pkg::OP_ZAP;
                twsi_pkg::NAME_NIP:  op = twsi_pkg::OP_NIP;
                twsi_pkg::NAME_SWAP: op = twsi_pkg::OP_SWAP;
                twsi_pkg::NAME_OVER: op = twsi_pkg::OP_OVER;
                twsi_pkg::NAME_LEAP: op = twsi_pkg::OP_LEAP;
                twsi_pkg::NAME_EQL:  op = twsi_pkg::OP_EQL;
                twsi_pkg::NAME_ZERO: op = twsi_pkg::OP_ZERO;
                default:             op = twsi_pkg::OP_NONE;
            endcase
        end
        case (op)
            twsi_pkg::OP_PUSH: begin need = 0; give = 1; end
            twsi_pkg::OP_DOT, twsi_pkg::OP_ZAP: begin need = 1; give = 0; end
            twsi_pkg::OP_ADD, twsi_pkg::OP_SUB, twsi_pkg::OP_MUL,
            twsi_pkg::OP_DIV, twsi_pkg::OP_NIP, twsi_pkg::OP_EQL:
            begin
                need = 2;
                give = 1;
            end
            twsi_pkg::OP_DUP: begin need = 1; give = 2; end
            twsi_pkg::OP_SWAP: begin need = 2; give = 2; end
            twsi_pkg::OP_OVER: begin need = 2; give = 3; end
            twsi_pkg::OP_LEAP: begin need = 3; give = 4; end
            twsi_pkg::OP_ZERO: begin need = 1; give = 1; end
            default: begin need = 0; give = 0; end
        endcase
        d = stack_fill;
        a = (d >= 1) ? word_stack[d - 1] : 32'd0;
        b = (d >= 2) ? word_stack[d - 2] : 32'd0;
        c = (d >= 3) ? word_stack[d - 3] : 32'd0;
        if (op != twsi_pkg::OP_NONE)
        begin
            if (d < need)
            begin
                o.status = twsi_pkg::STATUS_UNDER;
            end
            else if (d - need + give > STACK_DEPTH)
            begin
                o.status = twsi_pkg::STATUS_OVER;
            end
            else
            begin
                o.status = twsi_pkg::STATUS_DONE;
                case (op)
                    twsi_pkg::OP_PUSH:
                    begin
                        word_stack[d] = {{5{w[31]}}, w[31:5]};
                        d++;
                    end
                    twsi_pkg::OP_DOT:
                    begin
                        o.shown_valid = 1'b1;
                        o.shown_value = a;
                        d--;
                    end
                    twsi_pkg::OP_ADD: begin word_stack[d - 2] = b + a; d--; end
                    twsi_pkg::OP_SUB: begin word_stack[d - 2] = b - a; d--; end
                    twsi_pkg::OP_MUL: begin word_stack[d - 2] = b * a; d--; end
                    twsi_pkg::OP_DIV:
                    begin
                        if (a == 32'd0)
                        begin
                            o.status = twsi_pkg::STATUS_DIVZERO;
                        end
                        else
                        begin
                            // The most negative value over minus one wraps to itself.
                            if (b == 32'h8000_0000 && a == 32'hffff_ffff)
                                word_stack[d - 2] = 32'h8000_0000;
                            else
                                word_stack[d - 2] = $signed(b) / $signed(a);
                            d--;
                        end
                    end
                    twsi_pkg::OP_DUP: begin word_stack[d] = a; d++; end
                    twsi_pkg::OP_ZAP: d--;
                    twsi_pkg::OP_NIP: begin word_stack[d - 2] = a; d--; end
                    twsi_pkg::OP_SWAP:
                    begin
                        word_stack[d - 2] = a;
                        word_stack[d - 1] = b;
                    end
                    twsi_pkg::OP_OVER: begin word_stack[d] = b; d++; end
                    twsi_pkg::OP_LEAP: begin word_stack[d] = c; d++; end
                    twsi_pkg::OP_EQL:
                    begin
                        word_stack[d - 2] = (a == b) ? 32'd1 : 32'd0;
                        d--;
                    end
                    twsi_pkg::OP_ZERO: word_stack[d - 1] = (a == 32'd0) ? 32'd1 : 32'd0;
                    default: ;
                endcase
                stack_fill = d;
            end
        end
        o.depth = stack_fill[6:0];
        o.top_value = (stack_fill > 0) ? word_stack[stack_fill - 1] : 32'd0;
        return o;
    endfunction

    // Picks a word for the random part; push_pct biases the stack toward filling or draining.
    function automatic logic [31:0] pick_word(int push_pct);
        int          r;
        logic [26:0] val;
        logic [31:0] noise;
        r = $urandom_range(0, 99);
        noise = $urandom;
        if (r < 8)
            return noise;
        if (r < 11)
            return {noise[31:4], twsi_pkg::TAG_NAME};
        if ($urandom_range(0, 99) < push_pct)
        begin
            case ($urandom_range(0, 3))
                0: val = 27'd0;
                1: val = 27'($signed($urandom_range(0, 8)) - 4);
                2: val = noise[26:0];
                default: val = $urandom_range(0, 1) ? 27'h3ff_ffff : 27'h400_0000;
            endcase
            return {val, noise[4], twsi_pkg::TAG_NUMBER};
        end
        return {KNOWN_NAMES[$urandom_range(0, 15)][31:4], twsi_pkg::TAG_NAME};
    endfunction

    // Offers one request in bursts with random gaps and records its outcome once taken.
    task automatic send_request(input logic [31:0] w, input logic typed,
                                input outcome_t want);
        int       gap;
        outcome_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                src_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        src_valid <= 1'b1;
        source_word <= w;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        requests_taken++;
        predicted = interpret_word(w);
        pending_results.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", {29'd0, status}, 32'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", {29'd0, status}, {29'd0, want.status});
                if (shown_valid !== want.shown_valid)
                    report_mismatch("shown_valid", {31'd0, shown_valid},
                                    {31'd0, want.shown_valid});
                if (shown_value !== want.shown_value)
                    report_mismatch("shown_value", shown_value, want.shown_value);
                if (depth !== want.depth)
                    report_mismatch("depth", {25'd0, depth}, {25'd0, want.depth});
                if (top_value !== want.top_value)
                    report_mismatch("top_value", top_value, want.top_value);
            end
        end
    end

    // Result side: random stall pattern with one long hold-off to back up the input.
    initial
    begin
        int  stall_mode;
        int  stall_left;
        logic held_off;
        res_stall = 1'b0;
        stall_mode = 0;
        stall_left = 0;
        held_off = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && requests_taken >= 150)
            begin
                held_off = 1'b1;
                res_stall <= 1'b1;
                repeat (400) @(negedge clk);
            end
            else
            begin
                if (stall_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    stall_left = $urandom_range(64, 256);
                end
                stall_left--;
                case (stall_mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 7) == 0);
                    2: res_stall <= $urandom_range(0, 1);
                    default: res_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        logic [31:0] w;
        int          counted;
        int          phase_left;
        int          phase_kind;
        int          push_pct;
        int          waited;
        rst_n = 1'b0;
        src_valid = 1'b0;
        source_word = 32'd0;
        stack_fill = 0;
        mismatch_count = 0;
        requests_taken = 0;
        burst_left = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
            send_request(SCRIPT[i].word, SCRIPT[i].typed, SCRIPT[i].want);

        // Phases cycle through filling, mixed and draining so that both the full
        // and the empty stack are reached repeatedly.
        counted = 0;
        phase_left = 0;
        phase_kind = 2;
        push_pct = 0;
        while (counted < RANDOM_REQUESTS)
        begin
            if (phase_left == 0)
            begin
                phase_kind = (phase_kind + 1) % 3;
                phase_left = $urandom_range(70, 130);
                push_pct = (phase_kind == 0) ? 80 : (phase_kind == 1) ? 45 : 15;
            end
            phase_left--;
            w = pick_word(push_pct);
            send_request(w, 1'b0, NO_VALUE);
            counted++;
        end
        @(negedge clk);
        src_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", pending_results.size(), 32'd0);

        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
